/* rtl/i2c_master_bit_engine_top_macros.svh */
// Assertion macros for the I2C master bit engine.
// Used by the top level only; no other dependencies.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define I2CMBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define I2CMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define I2CMBE_ASSERT_NOW(lbl, ante, cons, msg)
`define I2CMBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/i2cmbe_pkg.sv */
// Types and constants shared by the I2C master bit engine modules.
// No dependencies.
`timescale 1ns / 1ps

package i2cmbe_pkg;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_STOP  = 3'd4
	} cmd_t;

	typedef enum logic [10:0] {
		PH_IDLE        = 11'b000_0000_0001,
		PH_START_RISE  = 11'b000_0000_0010,
		PH_START_SETUP = 11'b000_0000_0100,
		PH_START_HOLD  = 11'b000_0000_1000,
		PH_STOP_SETUP  = 11'b000_0001_0000,
		PH_STOP_RISE   = 11'b000_0010_0000,
		PH_STOP_HOLD   = 11'b000_0100_0000,
		PH_STOP_END    = 11'b000_1000_0000,
		PH_BIT_SETUP   = 11'b001_0000_0000,
		PH_BIT_RISE    = 11'b010_0000_0000,
		PH_BIT_HIGH    = 11'b100_0000_0000
	} phase_t;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_STRETCH = 2'd1,
		FAULT_SDA_LOW = 2'd2
	} fault_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_level;
		logic       scl_level;
	} item_t;

	localparam int unsigned CFG_HALF_PERIOD = 0;
	localparam int unsigned CFG_STRETCH     = 1;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
	localparam logic [15:0] STRETCH_RESET     = 16'd1000;
	localparam logic [3:0]  DATA_BITS         = 4'd8;

endpackage

/* rtl/i2cmbe_front.sv */
// Front end: accepts tick beats, classifies the command and queues them.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,  // write_data[7:0], send_ack[8], sda_level[9], scl_level[10]
	input  logic [2:0]          s_tuser,  // operation[2:0]
	output logic                q_valid,
	output i2cmbe_pkg::item_t   q_item,
	input  logic                q_pop
);

	i2cmbe_pkg::item_t fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	i2cmbe_pkg::item_t item_in;
	logic              push;

	always_comb begin
		case (s_tuser)
			i2cmbe_pkg::CMD_START: item_in.cmd = i2cmbe_pkg::CMD_START;
			i2cmbe_pkg::CMD_WRITE: item_in.cmd = i2cmbe_pkg::CMD_WRITE;
			i2cmbe_pkg::CMD_READ:  item_in.cmd = i2cmbe_pkg::CMD_READ;
			i2cmbe_pkg::CMD_STOP:  item_in.cmd = i2cmbe_pkg::CMD_STOP;
			default:               item_in.cmd = i2cmbe_pkg::CMD_NONE;
		endcase
		item_in.write_data = s_tdata[7:0];
		item_in.send_ack   = s_tdata[8];
		item_in.sda_level  = s_tdata[9];
		item_in.scl_level  = s_tdata[10];
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/i2cmbe_core.sv */
// Back end: bus condition sequencer, one queued tick per step, registered result beat.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  i2cmbe_pkg::item_t   q_item,
	output logic                q_pop,
	input  logic [15:0]         half_period,
	input  logic [15:0]         stretch_timeout,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata   // scl_pull_low[0], sda_pull_low[1], busy_res[2],
	                                      // done_res[3], read_data[11:4], acked[12], fault[14:13]
);

	i2cmbe_pkg::phase_t phase_q,   phase_d;
	i2cmbe_pkg::cmd_t   kind_q,    kind_d;
	i2cmbe_pkg::fault_t fault_q,   fault_d;
	logic [3:0]         bitc_q,    bitc_d;
	logic [7:0]         shift_q,   shift_d;
	logic               ackc_q,    ackc_d;
	logic [15:0]        delay_q,   delay_d;
	logic [15:0]        stretch_q, stretch_d;
	logic               scl_q,     scl_d;
	logic               sda_q,     sda_d;
	logic [7:0]         rdata_q,   rdata_d;
	logic               acked_q,   acked_d;
	logic               done_d;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	logic [16:0] delay_inc;
	logic        delay_over;
	logic [15:0] delay_wrap;
	logic [15:0] stretch_inc;
	logic        stretch_out;
	logic [3:0]  bitc_inc;
	logic        step;

	assign step  = q_valid && (!m_tvalid_q || m_tready);
	assign q_pop = step;

	assign delay_inc   = {1'b0, delay_q} + 17'd1;
	assign delay_over  = (delay_inc >= {1'b0, half_period});
	assign delay_wrap  = delay_over ? 16'd0 : delay_inc[15:0];
	assign stretch_inc = (stretch_q != 16'hFFFF) ? stretch_q + 16'd1 : stretch_q;
	assign stretch_out = (stretch_inc >= stretch_timeout);
	assign bitc_inc    = bitc_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		fault_d   = fault_q;
		bitc_d    = bitc_q;
		shift_d   = shift_q;
		ackc_d    = ackc_q;
		delay_d   = delay_q;
		stretch_d = stretch_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		rdata_d   = rdata_q;
		acked_d   = acked_q;
		done_d    = 1'b0;
		case (phase_q)
			i2cmbe_pkg::PH_IDLE: begin
				if (q_item.cmd != i2cmbe_pkg::CMD_NONE) begin
					kind_d    = q_item.cmd;
					fault_d   = i2cmbe_pkg::FAULT_NONE;
					delay_d   = 16'd0;
					stretch_d = 16'd0;
					bitc_d    = 4'd0;
					case (q_item.cmd)
						i2cmbe_pkg::CMD_START: begin
							sda_d   = 1'b0;
							scl_d   = 1'b0;
							phase_d = i2cmbe_pkg::PH_START_RISE;
						end
						i2cmbe_pkg::CMD_WRITE: begin
							shift_d = q_item.write_data;
							acked_d = 1'b0;
							sda_d   = ~q_item.write_data[7];
							phase_d = i2cmbe_pkg::PH_BIT_SETUP;
						end
						i2cmbe_pkg::CMD_READ: begin
							shift_d = 8'd0;
							ackc_d  = q_item.send_ack;
							sda_d   = 1'b0;
							phase_d = i2cmbe_pkg::PH_BIT_SETUP;
						end
						default: begin
							sda_d   = 1'b1;
							phase_d = i2cmbe_pkg::PH_STOP_SETUP;
						end
					endcase
				end
			end
			i2cmbe_pkg::PH_START_RISE: begin
				if (q_item.scl_level) begin
					if (!q_item.sda_level) begin
						sda_d   = 1'b0;
						phase_d = i2cmbe_pkg::PH_IDLE;
						done_d  = 1'b1;
						fault_d = i2cmbe_pkg::FAULT_SDA_LOW;
					end else begin
						delay_d = 16'd0;
						phase_d = i2cmbe_pkg::PH_START_SETUP;
					end
				end else begin
					stretch_d = stretch_inc;
					if (stretch_out) begin
						phase_d = i2cmbe_pkg::PH_IDLE;
						done_d  = 1'b1;
						fault_d = i2cmbe_pkg::FAULT_STRETCH;
					end
				end
			end
			i2cmbe_pkg::PH_START_SETUP: begin
				delay_d = delay_wrap;
				if (delay_over) begin
					sda_d   = 1'b1;
					phase_d = i2cmbe_pkg::PH_START_HOLD;
				end
			end
			i2cmbe_pkg::PH_START_HOLD: begin
				delay_d = delay_wrap;
				if (delay_over) begin
					scl_d   = 1'b1;
					phase_d = i2cmbe_pkg::PH_IDLE;
					done_d  = 1'b1;
					fault_d = i2cmbe_pkg::FAULT_NONE;
				end
			end
			i2cmbe_pkg::PH_STOP_SETUP: begin
				delay_d = delay_wrap;
				if (delay_over) begin
					scl_d     = 1'b0;
					stretch_d = 16'd0;
					phase_d   = i2cmbe_pkg::PH_STOP_RISE;
				end
			end
			i2cmbe_pkg::PH_STOP_RISE: begin
				if (q_item.scl_level) begin
					delay_d = 16'd0;
					phase_d = i2cmbe_pkg::PH_STOP_HOLD;
				end else begin
					stretch_d = stretch_inc;
					if (stretch_out) begin
						sda_d   = 1'b0;
						phase_d = i2cmbe_pkg::PH_IDLE;
						done_d  = 1'b1;
						fault_d = i2cmbe_pkg::FAULT_NONE;
					end
				end
			end
			i2cmbe_pkg::PH_STOP_HOLD: begin
				delay_d = delay_wrap;
				if (delay_over) begin
					sda_d   = 1'b0;
					phase_d = i2cmbe_pkg::PH_STOP_END;
				end
			end
			i2cmbe_pkg::PH_STOP_END: begin
				delay_d = delay_wrap;
				if (delay_over) begin
					phase_d = i2cmbe_pkg::PH_IDLE;
					done_d  = 1'b1;
					fault_d = i2cmbe_pkg::FAULT_NONE;
				end
			end
			i2cmbe_pkg::PH_BIT_SETUP: begin
				delay_d = delay_wrap;
				if (delay_over) begin
					scl_d     = 1'b0;
					stretch_d = 16'd0;
					phase_d   = i2cmbe_pkg::PH_BIT_RISE;
				end
			end
			i2cmbe_pkg::PH_BIT_RISE: begin
				if (q_item.scl_level) begin
					if (bitc_q < i2cmbe_pkg::DATA_BITS) begin
						if (kind_q == i2cmbe_pkg::CMD_READ) begin
							shift_d = {shift_q[6:0], q_item.sda_level};
						end
					end else if (kind_q == i2cmbe_pkg::CMD_WRITE) begin
						acked_d = ~q_item.sda_level;
					end
					delay_d = 16'd0;
					phase_d = i2cmbe_pkg::PH_BIT_HIGH;
				end else begin
					stretch_d = stretch_inc;
					if (stretch_out) begin
						phase_d = i2cmbe_pkg::PH_IDLE;
						done_d  = 1'b1;
						fault_d = i2cmbe_pkg::FAULT_STRETCH;
					end
				end
			end
			i2cmbe_pkg::PH_BIT_HIGH: begin
				delay_d = delay_wrap;
				if (delay_over) begin
					scl_d  = 1'b1;
					bitc_d = bitc_inc;
					if (bitc_inc < i2cmbe_pkg::DATA_BITS) begin
						if (kind_q == i2cmbe_pkg::CMD_WRITE) begin
							sda_d = ~shift_q[3'd7 - bitc_inc[2:0]];
						end
						phase_d = i2cmbe_pkg::PH_BIT_SETUP;
					end else if (bitc_inc == i2cmbe_pkg::DATA_BITS) begin
						sda_d   = (kind_q == i2cmbe_pkg::CMD_READ) ? ackc_q : 1'b0;
						phase_d = i2cmbe_pkg::PH_BIT_SETUP;
					end else begin
						if (kind_q == i2cmbe_pkg::CMD_READ) begin
							sda_d   = 1'b0;
							rdata_d = shift_q;
						end
						phase_d = i2cmbe_pkg::PH_IDLE;
						done_d  = 1'b1;
						fault_d = i2cmbe_pkg::FAULT_NONE;
					end
				end
			end
			default: begin
				phase_d = i2cmbe_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= i2cmbe_pkg::PH_IDLE;
			kind_q     <= i2cmbe_pkg::CMD_NONE;
			fault_q    <= i2cmbe_pkg::FAULT_NONE;
			bitc_q     <= 4'd0;
			shift_q    <= 8'd0;
			ackc_q     <= 1'b0;
			delay_q    <= 16'd0;
			stretch_q  <= 16'd0;
			scl_q      <= 1'b0;
			sda_q      <= 1'b0;
			rdata_q    <= 8'd0;
			acked_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			kind_q     <= kind_d;
			fault_q    <= fault_d;
			bitc_q     <= bitc_d;
			shift_q    <= shift_d;
			ackc_q     <= ackc_d;
			delay_q    <= delay_d;
			stretch_q  <= stretch_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			rdata_q    <= rdata_d;
			acked_q    <= acked_d;
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata_q <= {1'b0, fault_d, acked_d, rdata_d, done_d,
				(phase_d != i2cmbe_pkg::PH_IDLE), sda_d, scl_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* rtl/i2c_master_bit_engine_top.sv */
// Top level of the I2C master bit engine: APB register file, front queue, back-end sequencer.
// Depends on i2cmbe_pkg, i2cmbe_front, i2cmbe_core and the macro header.
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_top_macros.svh"

// One slave beat is one bus tick carrying the sampled SDA/SCL levels and an optional
// command (start, write byte, read byte, stop; taken only while idle). Every tick yields
// exactly one master beat with the pull-low enables, busy, a one-tick done pulse, the last
// read byte, the ack of the last written byte and the fault code of the last command.
// Throughput is one tick per clock unless the result stream stalls: a two-entry queue
// feeds a single-step sequencer whose result register is reloaded whenever it is empty
// or being taken; a tick is queued, then popped and registered. Registers: half_period_ticks
// at byte 0x0, stretch_timeout_ticks at 0x4; write them only while the engine is idle.

module i2c_master_bit_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // write_data[7:0], send_ack[8], sda_level[9], scl_level[10]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // scl_pull_low[0], sda_pull_low[1], busy_res[2],
	                               // done_res[3], read_data[11:4], acked[12], fault[14:13]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]       half_q;
	logic [15:0]       stretch_q;
	logic              cfg_wr;
	logic              q_valid;
	logic              q_pop;
	i2cmbe_pkg::item_t q_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= i2cmbe_pkg::HALF_PERIOD_RESET;
			stretch_q <= i2cmbe_pkg::STRETCH_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == 1'(i2cmbe_pkg::CFG_HALF_PERIOD)) begin
				half_q <= pwdata[15:0];
			end else begin
				stretch_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = (paddr[2] == 1'(i2cmbe_pkg::CFG_STRETCH)) ? {16'd0, stretch_q}
		: {16'd0, half_q};

	i2cmbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	i2cmbe_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.half_period     (half_q),
		.stretch_timeout (stretch_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

	`I2CMBE_ASSERT_NOW(a_done_not_busy, m_tvalid && m_tdata[3], !m_tdata[2], "done while busy")
	`I2CMBE_ASSERT_NOW(a_fault_code, m_tvalid, m_tdata[14:13] != 2'b11, "illegal fault code")
	`I2CMBE_ASSERT_NEXT(a_cfg_half, cfg_wr && !paddr[2], half_q == $past(pwdata[15:0]), "write lost")
	`I2CMBE_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "pop from empty queue")

endmodule

/* bench/engine_scoreboard.sv */
// Scoreboard for the I2C master bit engine bench: predicts the status beat of every accepted
// bus tick from its own copy of the engine state and checks the beats the engine returns.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

package engine_check_pkg;
	import i2cmbe_pkg::*;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] wd;
		logic       ack;
		logic       sda;
		logic       scl;
	} tick_t;

	typedef struct packed {
		logic [1:0] fault;
		logic       acked;
		logic [7:0] rd;
		logic       done;
		logic       busy;
		logic       sda;
		logic       scl;
	} status_t;

	typedef enum {RISE_WAIT, RISE_HIGH, RISE_TIMEOUT} rise_t;

	class engine_scoreboard;
		logic [15:0] half_period;
		logic [15:0] stretch_limit;
		phase_t      ph;
		logic [2:0]  kind;
		logic [3:0]  bit_cnt;
		logic [7:0]  shreg;
		logic        ack_sel;
		logic [15:0] dly;
		logic [15:0] str;
		logic        scl_drv;
		logic        sda_drv;
		logic [7:0]  rd_byte;
		logic        ack_seen;
		fault_t      flt;
		logic        done;
		status_t     expected_status[$];
		int          ticks_seen;
		int          beats_seen;
		int          errors;

		function new();
			half_period = HALF_PERIOD_RESET;
			stretch_limit = STRETCH_RESET;
			ph = PH_IDLE;
			kind = CMD_NONE;
			bit_cnt = '0;
			shreg = '0;
			ack_sel = 1'b0;
			dly = '0;
			str = '0;
			scl_drv = 1'b0;
			sda_drv = 1'b0;
			rd_byte = '0;
			ack_seen = 1'b0;
			flt = FAULT_NONE;
			done = 1'b0;
			ticks_seen = 0;
			beats_seen = 0;
			errors = 0;
		endfunction

		function void configure(int unsigned idx, logic [15:0] val);
			if (idx == CFG_HALF_PERIOD) half_period = val;
			else if (idx == CFG_STRETCH) stretch_limit = val;
		endfunction

		function void log_error(string msg);
			errors++;
			if (errors <= 10) $display("%s", msg);
		endfunction

		function bit delay_done();
			if ({1'b0, dly} + 17'd1 >= {1'b0, half_period}) begin
				dly = '0;
				return 1'b1;
			end
			dly = dly + 16'd1;
			return 1'b0;
		endfunction

		function rise_t rise_state(logic scl);
			if (scl) return RISE_HIGH;
			if (str != 16'hFFFF) str = str + 16'd1;
			if (str >= stretch_limit) return RISE_TIMEOUT;
			return RISE_WAIT;
		endfunction

		function void finish(fault_t code);
			ph = PH_IDLE;
			done = 1'b1;
			flt = code;
		endfunction

		function void advance(tick_t t);
			rise_t r;
			done = 1'b0;
			case (ph)
				PH_IDLE: begin
					if (t.op >= CMD_START && t.op <= CMD_STOP) begin
						kind = t.op;
						flt = FAULT_NONE;
						dly = '0;
						str = '0;
						bit_cnt = '0;
						case (t.op)
							CMD_START: begin
								sda_drv = 1'b0;
								scl_drv = 1'b0;
								ph = PH_START_RISE;
							end
							CMD_WRITE: begin
								shreg = t.wd;
								ack_seen = 1'b0;
								sda_drv = ~t.wd[7];
								ph = PH_BIT_SETUP;
							end
							CMD_READ: begin
								shreg = '0;
								ack_sel = t.ack;
								sda_drv = 1'b0;
								ph = PH_BIT_SETUP;
							end
							default: begin
								sda_drv = 1'b1;
								ph = PH_STOP_SETUP;
							end
						endcase
					end
				end
				PH_START_RISE: begin
					r = rise_state(t.scl);
					if (r == RISE_HIGH) begin
						if (!t.sda) begin
							sda_drv = 1'b0;
							finish(FAULT_SDA_LOW);
						end else begin
							dly = '0;
							ph = PH_START_SETUP;
						end
					end else if (r == RISE_TIMEOUT) begin
						finish(FAULT_STRETCH);
					end
				end
				PH_START_SETUP: begin
					if (delay_done()) begin
						sda_drv = 1'b1;
						ph = PH_START_HOLD;
					end
				end
				PH_START_HOLD: begin
					if (delay_done()) begin
						scl_drv = 1'b1;
						finish(FAULT_NONE);
					end
				end
				PH_STOP_SETUP: begin
					if (delay_done()) begin
						scl_drv = 1'b0;
						str = '0;
						ph = PH_STOP_RISE;
					end
				end
				PH_STOP_RISE: begin
					r = rise_state(t.scl);
					if (r == RISE_HIGH) begin
						dly = '0;
						ph = PH_STOP_HOLD;
					end else if (r == RISE_TIMEOUT) begin
						sda_drv = 1'b0;
						finish(FAULT_NONE);
					end
				end
				PH_STOP_HOLD: begin
					if (delay_done()) begin
						sda_drv = 1'b0;
						ph = PH_STOP_END;
					end
				end
				PH_STOP_END: begin
					if (delay_done()) finish(FAULT_NONE);
				end
				PH_BIT_SETUP: begin
					if (delay_done()) begin
						scl_drv = 1'b0;
						str = '0;
						ph = PH_BIT_RISE;
					end
				end
				PH_BIT_RISE: begin
					r = rise_state(t.scl);
					if (r == RISE_HIGH) begin
						if (bit_cnt < DATA_BITS) begin
							if (kind == CMD_READ) shreg = {shreg[6:0], t.sda};
						end else if (kind == CMD_WRITE) begin
							ack_seen = ~t.sda;
						end
						dly = '0;
						ph = PH_BIT_HIGH;
					end else if (r == RISE_TIMEOUT) begin
						finish(FAULT_STRETCH);
					end
				end
				PH_BIT_HIGH: begin
					if (delay_done()) begin
						scl_drv = 1'b1;
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt < DATA_BITS) begin
							if (kind == CMD_WRITE)
								sda_drv = ~shreg[3'(DATA_BITS - 4'd1 - bit_cnt)];
							ph = PH_BIT_SETUP;
						end else if (bit_cnt == DATA_BITS) begin
							sda_drv = (kind == CMD_READ) ? ack_sel : 1'b0;
							ph = PH_BIT_SETUP;
						end else begin
							if (kind == CMD_READ) begin
								sda_drv = 1'b0;
								rd_byte = shreg;
							end
							finish(FAULT_NONE);
						end
					end
				end
				default: ph = PH_IDLE;
			endcase
		endfunction

		function void note(tick_t t);
			status_t s;
			advance(t);
			s.scl = scl_drv;
			s.sda = sda_drv;
			s.busy = (ph != PH_IDLE);
			s.done = done;
			s.rd = rd_byte;
			s.acked = ack_seen;
			s.fault = flt;
			expected_status.push_back(s);
			ticks_seen++;
		endfunction

		function void check(logic [15:0] data);
			status_t got;
			status_t want;
			got = status_t'(data[14:0]);
			beats_seen++;
			if (expected_status.size() == 0) begin
				log_error($sformatf("status beat %0d arrived with nothing expected: %h",
					beats_seen, data));
				return;
			end
			want = expected_status.pop_front();
			if (got !== want)
				log_error($sformatf({"status beat %0d: expected scl=%b sda=%b busy=%b done=%b",
					" read=%h acked=%b fault=%0d, got scl=%b sda=%b busy=%b done=%b read=%h",
					" acked=%b fault=%0d"}, beats_seen,
					want.scl, want.sda, want.busy, want.done, want.rd, want.acked, want.fault,
					got.scl, got.sda, got.busy, got.done, got.rd, got.acked, got.fault));
		endfunction
	endclass

endpackage

/* bench/tb_top.sv */
// Top of the I2C master bit engine bench: drives bus ticks modeled on the engine's own pin
// drives, random stalls on both streams and APB register writes; checks every status beat.
// Depends on i2cmbe_pkg, engine_check_pkg and the i2c_master_bit_engine_top RTL.
`timescale 1ns / 1ps

module tb_top;
	import i2cmbe_pkg::*;
	import engine_check_pkg::*;

	localparam int          IDLE_PCT     = 24;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          RANDOM_TICKS = 100;
	localparam longint      CYCLE_LIMIT  = 5000000;
	localparam logic [2:0]  OP_MAX       = 3'h7;
	localparam logic [15:0] TICKS_MAX    = 16'hFFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = CMD_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	engine_scoreboard sb;
	longint           cycle_count = 0;
	bit               steady = 1'b0;

	bit               noisy;
	bit               busy_ops;
	bit               start_sda_low;
	bit               slave_ack;
	logic [7:0]       slave_byte;
	int               stretch_rise;
	int               stretch_len;

	i2c_master_bit_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check(m_tdata);
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void plan_clean();
		noisy = 1'b0;
		busy_ops = 1'b0;
		start_sda_low = 1'b0;
		slave_ack = 1'b1;
		slave_byte = 8'($urandom);
		stretch_rise = -1;
		stretch_len = 0;
	endfunction

	function automatic void plan_random();
		int pick;
		int lim;
		pick = $urandom_range(99);
		lim = int'(sb.stretch_limit);
		noisy = 1'b1;
		busy_ops = 1'b1;
		start_sda_low = ($urandom_range(19) == 0);
		slave_ack = ($urandom_range(3) != 0);
		slave_byte = 8'($urandom);
		stretch_rise = -1;
		stretch_len = 0;
		if (pick >= 70) begin
			stretch_rise = $urandom_range(9);
			if (pick < 92 && lim > 1) stretch_len = $urandom_range(1, lim - 1);
			else stretch_len = (lim == 0) ? 1 : lim;
		end
	endfunction

	task automatic send_tick(input tick_t t);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= t.op;
		s_tdata <= {5'b0, t.scl, t.sda, t.ack, t.wd};
		do @(posedge clk); while (!s_tready);
		sb.note(t);
	endtask

	// Issue one operation, then play the bus until the engine is idle again.
	task automatic run_command(input logic [2:0] op, input logic [7:0] wd, input logic ack);
		tick_t  t;
		bit     first;
		bit     rising;
		int     rise_idx;
		int     stretch_left;
		phase_t last_ph;
		first = 1'b1;
		rise_idx = 0;
		stretch_left = 0;
		last_ph = PH_IDLE;
		do begin
			rising = (sb.ph == PH_START_RISE || sb.ph == PH_STOP_RISE || sb.ph == PH_BIT_RISE);
			if (rising && sb.ph != last_ph) begin
				if (rise_idx == stretch_rise) stretch_left = stretch_len;
				else if (noisy && $urandom_range(9) == 0) stretch_left = $urandom_range(1, 2);
				else stretch_left = 0;
				rise_idx++;
			end
			last_ph = sb.ph;
			t.wd = first ? wd : 8'($urandom);
			t.ack = first ? ack : 1'($urandom);
			if (first) t.op = op;
			else if (busy_ops && $urandom_range(19) == 0) t.op = 3'($urandom_range(CMD_START, OP_MAX));
			else t.op = CMD_NONE;
			if (sb.scl_drv) begin
				t.scl = 1'b0;
			end else if (rising && stretch_left > 0) begin
				t.scl = 1'b0;
				stretch_left--;
			end else begin
				t.scl = 1'b1;
			end
			if (sb.sda_drv)
				t.sda = 1'b0;
			else if (sb.ph == PH_START_RISE)
				t.sda = !start_sda_low;
			else if (sb.ph == PH_BIT_RISE && sb.kind == CMD_WRITE && sb.bit_cnt == DATA_BITS)
				t.sda = !slave_ack;
			else if (sb.ph == PH_BIT_RISE && sb.kind == CMD_READ && sb.bit_cnt < DATA_BITS)
				t.sda = slave_byte[3'(DATA_BITS - 4'd1 - sb.bit_cnt)];
			else
				t.sda = 1'b1;
			if (noisy && $urandom_range(49) == 0) {t.sda, t.scl} = 2'($urandom);
			send_tick(t);
			first = 1'b0;
		end while (sb.ph != PH_IDLE);
	endtask

	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (sb.expected_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input int unsigned idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.configure(idx, val);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== val)
			sb.log_error($sformatf("register %0d read back %h, expected %h", idx, prdata, val));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_timing(input logic [15:0] half, input logic [15:0] limit);
		quiesce();
		reg_write(CFG_HALF_PERIOD, half);
		reg_write(CFG_STRETCH, limit);
	endtask

	task automatic random_transaction();
		int pick;
		pick = $urandom_range(99);
		if (pick < 80) begin
			plan_random();
			run_command(CMD_START, 8'($urandom), 1'($urandom));
			repeat ($urandom_range(1, 3)) begin
				plan_random();
				if ($urandom_range(1) == 0) run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
				else run_command(CMD_READ, 8'($urandom), 1'($urandom));
			end
			plan_random();
			run_command(CMD_STOP, 8'($urandom), 1'($urandom));
		end else if (pick < 92) begin
			plan_random();
			run_command(3'($urandom), 8'($urandom), 1'($urandom));
		end else begin
			plan_random();
			repeat ($urandom_range(1, 4)) run_command(CMD_NONE, 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int          start_ticks;
		logic [15:0] half_set[4];
		logic [15:0] limit_set[4];
		sb = new();
		half_set = '{16'd2, 16'd1, 16'd0, 16'd3};
		limit_set = '{16'd6, 16'd1, 16'd4, 16'd20};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register reset values
		plan_clean();
		run_command(CMD_NONE, 8'h00, 1'b0);
		run_command(CMD_NONE, 8'hFF, 1'b1);
		for (int k = CMD_STOP + 1; k <= OP_MAX; k++) run_command(3'(k), 8'($urandom), 1'b0);
		run_command(CMD_START, 8'h00, 1'b0);
		slave_ack = 1'b1;
		run_command(CMD_WRITE, 8'hFF, 1'b0);
		slave_ack = 1'b0;
		run_command(CMD_WRITE, 8'h00, 1'b1);
		slave_byte = 8'hFF;
		run_command(CMD_READ, 8'h00, 1'b1);
		slave_byte = 8'h00;
		run_command(CMD_READ, 8'hFF, 1'b0);
		run_command(CMD_STOP, 8'h00, 1'b0);
		busy_ops = 1'b1;
		run_command(CMD_START, 8'h5A, 1'b1);
		run_command(CMD_STOP, 8'hA5, 1'b1);
		plan_clean();
		start_sda_low = 1'b1;
		run_command(CMD_START, 8'h00, 1'b0);
		plan_clean();
		run_command(CMD_STOP, 8'h00, 1'b0);

		// stretch just inside and at the timeout
		set_timing(16'd1, 16'd3);
		plan_clean();
		stretch_rise = 0;
		stretch_len = 2;
		run_command(CMD_START, 8'h00, 1'b0);
		plan_clean();
		stretch_rise = 8;
		stretch_len = 3;
		run_command(CMD_WRITE, 8'hA5, 1'b0);
		plan_clean();
		slave_byte = 8'h3C;
		run_command(CMD_READ, 8'h00, 1'b1);
		stretch_rise = 4;
		stretch_len = 3;
		run_command(CMD_READ, 8'h00, 1'b0);
		plan_clean();
		stretch_rise = 0;
		stretch_len = 3;
		run_command(CMD_STOP, 8'h00, 1'b0);
		run_command(CMD_START, 8'h00, 1'b0);

		// zero half period and zero stretch timeout
		set_timing(16'd0, 16'd0);
		plan_clean();
		run_command(CMD_START, 8'h00, 1'b0);
		run_command(CMD_WRITE, 8'h81, 1'b0);
		run_command(CMD_READ, 8'h00, 1'b1);
		stretch_rise = 0;
		stretch_len = 1;
		run_command(CMD_WRITE, 8'h7E, 1'b0);
		run_command(CMD_STOP, 8'h00, 1'b0);

		// full-scale registers on short commands
		set_timing(TICKS_MAX, 16'd8);
		plan_clean();
		start_sda_low = 1'b1;
		run_command(CMD_START, 8'h00, 1'b0);

		set_timing(16'd1, TICKS_MAX);
		plan_clean();
		run_command(CMD_START, 8'h00, 1'b0);
		run_command(CMD_STOP, 8'h00, 1'b0);

		for (int s = 0; s < 4; s++) begin
			set_timing(half_set[s], limit_set[s]);
			steady = (s == 1);
			start_ticks = sb.ticks_seen;
			while (sb.ticks_seen - start_ticks < RANDOM_TICKS) random_transaction();
		end
		steady = 1'b0;

		quiesce();
		if (sb.errors == 0 && sb.expected_status.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
